@@ rtl/sparse_matrix_vector_engine_core_defines.svh @@
// ----------------------------------------------------------------------------
// sparse_matrix_vector_engine_core_defines
// Assertion macros shared by the sparse matrix/vector engine RTL.
// ----------------------------------------------------------------------------
`ifndef SPARSE_MATRIX_VECTOR_ENGINE_CORE_DEFINES_SVH
`define SPARSE_MATRIX_VECTOR_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SMVE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SMVE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/smve_pkg.sv @@
// ----------------------------------------------------------------------------
// smve_pkg
// Types and constants for the sparse matrix/vector engine.
// ----------------------------------------------------------------------------
`default_nettype none

package smve_pkg;

  localparam int MAX_DIM_DEF = 64;
  localparam int MAX_NNZ_DEF = 256;

  localparam int PTR_W   = 9;
  localparam int SLOT_W  = 8;
  localparam int INNER_W = 6;
  localparam int NUM_W   = 32;
  localparam int OP_W    = 3;
  localparam int ACC_W   = 64;
  localparam int CNT_W   = 7;

  typedef enum logic [1:0] {
    ACT_LOAD_PTR = 2'd0,
    ACT_LOAD_NZ  = 2'd1,
    ACT_LOAD_VEC = 2'd2,
    ACT_START    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    CFG_ROW_COUNT = 2'd0,
    CFG_COL_COUNT = 2'd1,
    CFG_FORMAT    = 2'd2
  } cfg_reg_t;

  localparam logic [OP_W-1:0] OP_AX      = 3'd0;
  localparam logic [OP_W-1:0] OP_ATX     = 3'd1;
  localparam logic [OP_W-1:0] OP_ROW_MAX = 3'd2;
  localparam logic [OP_W-1:0] OP_COL_MAX = 3'd3;
  localparam logic [OP_W-1:0] OP_ROW_L1  = 3'd4;
  localparam logic [OP_W-1:0] OP_COL_L1  = 3'd5;

  typedef enum logic [1:0] {
    K_MUL = 2'd0,
    K_MAX = 2'd1,
    K_SUM = 2'd2
  } alu_kind_t;

  typedef struct packed {
    logic      load;
    alu_kind_t kind;
  } alu_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PTR0,
    ST_LD0,
    ST_PTR,
    ST_LDE,
    ST_ENT,
    ST_ENTW,
    ST_MUL,
    ST_ACC,
    ST_OUT,
    ST_OUTW,
    ST_SEND
  } state_t;

endpackage

`default_nettype wire

@@ rtl/smve_alu.sv @@
// ----------------------------------------------------------------------------
// smve_alu
// Shared arithmetic unit: registered product or magnitude, then a saturating
// add or a max against the old accumulator value.
// ----------------------------------------------------------------------------
`default_nettype none

module smve_alu
  import smve_pkg::*;
(
  input  wire logic                    clk,
  input  wire alu_ctrl_t               ctrl,
  input  wire logic signed [NUM_W-1:0] nz_value,
  input  wire logic signed [NUM_W-1:0] vec_value,
  input  wire logic signed [ACC_W-1:0] acc_old,
  output logic signed [ACC_W-1:0]      acc_new
);

  logic signed [ACC_W-1:0] term_r, term_nxt;
  alu_kind_t               kind_r;
  logic        [NUM_W-1:0] abs_v;
  logic        [ACC_W:0]   sum;

  always_comb begin
    abs_v = nz_value[NUM_W-1] ? (~nz_value + 1'b1) : nz_value;
    if (ctrl.kind == K_MUL) begin
      term_nxt = nz_value * vec_value;
    end else begin
      term_nxt = {16'd0, abs_v, 16'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      term_r <= term_nxt;
      kind_r <= ctrl.kind;
    end
  end

  always_comb begin
    sum = {acc_old[ACC_W-1], acc_old} + {term_r[ACC_W-1], term_r};
    if (kind_r == K_MAX) begin
      acc_new = (term_r > acc_old) ? term_r : acc_old;
    end else if (sum[ACC_W] != sum[ACC_W-1]) begin
      // signed overflow: clamp to the bound on the side of the true sign
      acc_new = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_new = sum[ACC_W-1:0];
    end
  end

endmodule

`default_nettype wire

@@ rtl/sparse_matrix_vector_engine_core.sv @@
// Load items never raise in_stall. A start steps through PTR0 and LD0, then
// PTR, LDE and ENT per outer slice and ENT, ENTW, MUL and ACC per nonzero
// (ENT and ENTW only when its inner index is out of range) on one shared ALU,
// then OUT, OUTW and SEND per output element plus any output stall.
// Throughput is one item at a time; in_stall is high for the whole run.
// Reset (synchronous, rst_n low) clears config, state, counters, acc valid bits.
// ----------------------------------------------------------------------------
// sparse_matrix_vector_engine_core
// CSR/CSC sparse matrix engine: loads, then Ax, A^T x, max-abs and L1 norms.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_matrix_vector_engine_core
  import smve_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF,
  parameter int MAX_NNZ = MAX_NNZ_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [1:0]              in_action,
  input  wire logic [SLOT_W-1:0]       in_slot,
  input  wire logic [PTR_W-1:0]        in_pointer_value,
  input  wire logic [INNER_W-1:0]      in_inner_position,
  input  wire logic signed [NUM_W-1:0] in_number_in,
  input  wire logic [OP_W-1:0]         in_operation,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [INNER_W-1:0]           out_element_position,
  output logic signed [NUM_W-1:0]      out_element_value,
  output logic                         out_last,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [1:0]              cfg_index,
  input  wire logic [CNT_W-1:0]        cfg_data
);

  `include "sparse_matrix_vector_engine_core_defines.svh"

  localparam int DAW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DCW = $clog2(MAX_DIM + 1);
  localparam int SAW = $clog2(MAX_DIM + 1);
  localparam int EAW = (MAX_NNZ > 1) ? $clog2(MAX_NNZ) : 1;

  // memories
  logic        [PTR_W-1:0]   slice_mem [MAX_DIM+1];
  logic        [INNER_W-1:0] epos_mem  [MAX_NNZ];
  logic signed [NUM_W-1:0]   eval_mem  [MAX_NNZ];
  logic signed [NUM_W-1:0]   vec_mem   [MAX_DIM];
  logic signed [ACC_W-1:0]   acc_mem   [MAX_DIM];
  logic        [MAX_DIM-1:0] acc_vld_r;

  logic        [PTR_W-1:0]   slice_rd_r;
  logic        [INNER_W-1:0] epos_rd_r;
  logic signed [NUM_W-1:0]   eval_rd_r;
  logic signed [NUM_W-1:0]   vec_rd_r;
  logic signed [ACC_W-1:0]   acc_rd_r;
  logic                      acc_vld_rd_r;

  // config
  logic [CNT_W-1:0] row_count_r, col_count_r;
  logic             fmt_r;

  // run state
  state_t            state_r, state_nxt;
  logic [OP_W-1:0]   op_r;
  logic              run_fmt_r;
  logic [DCW-1:0]    outer_n_r, inner_n_r, out_n_r;
  logic [DCW-1:0]    k_r, k_nxt;
  logic [DCW-1:0]    j_r, j_nxt;
  logic [PTR_W-1:0]  p_r, p_nxt;
  logic [PTR_W-1:0]  end_r, end_nxt;
  logic [DAW-1:0]    tgt_r, tgt_nxt;

  logic              in_xfer, start_go, out_xfer;
  logic [DCW-1:0]    rows_c, cols_c;
  logic [PTR_W-1:0]  slice_clamp;
  logic [DAW-1:0]    r_idx, c_idx, vec_idx;
  logic              skip;

  logic              slice_re, ent_re, vec_re, acc_we;
  logic [SAW-1:0]    slice_ra;
  logic [DAW-1:0]    acc_ra;
  alu_ctrl_t         alu_ctrl;
  logic signed [ACC_W-1:0] acc_old, acc_new, acc_fin;

  logic [INNER_W-1:0]      out_pos_r;
  logic signed [NUM_W-1:0] out_val_r;
  logic                    out_last_r;

  function automatic logic [DCW-1:0] clamp_dim(input logic [CNT_W-1:0] n);
    if (32'(n) > MAX_DIM) return DCW'(MAX_DIM);
    return DCW'(n);
  endfunction

  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && !in_stall;
  assign start_go  = in_xfer && (in_action == ACT_START) && (in_operation <= OP_COL_L1);
  assign out_xfer  = out_valid && !out_stall;
  assign rows_c    = clamp_dim(row_count_r);
  assign cols_c    = clamp_dim(col_count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= '0;
      col_count_r <= '0;
      fmt_r       <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ROW_COUNT: row_count_r <= cfg_data;
        CFG_COL_COUNT: col_count_r <= cfg_data;
        CFG_FORMAT:    fmt_r       <= cfg_data[0];
        default:       ;
      endcase
    end
  end

  // loads
  always_ff @(posedge clk) begin
    if (in_xfer && in_action == ACT_LOAD_PTR && 32'(in_slot) <= MAX_DIM) begin
      slice_mem[SAW'(in_slot)] <= in_pointer_value;
    end
    if (in_xfer && in_action == ACT_LOAD_NZ && 32'(in_slot) < MAX_NNZ) begin
      epos_mem[EAW'(in_slot)] <= in_inner_position;
      eval_mem[EAW'(in_slot)] <= in_number_in;
    end
    if (in_xfer && in_action == ACT_LOAD_VEC && 32'(in_slot) < MAX_DIM) begin
      vec_mem[DAW'(in_slot)] <= in_number_in;
    end
  end

  // memory reads
  assign slice_ra = (state_r == ST_PTR0) ? '0 : SAW'(k_r + 1'b1);
  assign acc_ra   = (state_r == ST_OUT) ? DAW'(j_r) : tgt_r;

  always_ff @(posedge clk) begin
    if (slice_re) slice_rd_r <= slice_mem[slice_ra];
    if (ent_re) begin
      epos_rd_r <= epos_mem[EAW'(p_r)];
      eval_rd_r <= eval_mem[EAW'(p_r)];
    end
    if (vec_re) vec_rd_r <= vec_mem[vec_idx];
    acc_rd_r     <= acc_mem[acc_ra];
    acc_vld_rd_r <= acc_vld_r[acc_ra];
    if (acc_we) acc_mem[tgt_r] <= acc_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_vld_r <= '0;
    end else if (start_go) begin
      acc_vld_r <= '0;
    end else if (acc_we) begin
      acc_vld_r[tgt_r] <= 1'b1;
    end
  end

  always_comb begin
    slice_clamp = (32'(slice_rd_r) > MAX_NNZ) ? PTR_W'(MAX_NNZ) : slice_rd_r;
    skip    = (32'(epos_rd_r) >= 32'(inner_n_r));
    r_idx   = run_fmt_r ? DAW'(epos_rd_r) : DAW'(k_r);
    c_idx   = run_fmt_r ? DAW'(k_r) : DAW'(epos_rd_r);
    vec_idx = op_r[0] ? r_idx : c_idx;
    acc_old = acc_vld_rd_r ? acc_rd_r : '0;
  end

  smve_alu u_alu (
    .clk       (clk),
    .ctrl      (alu_ctrl),
    .nz_value  (eval_rd_r),
    .vec_value (vec_rd_r),
    .acc_old   (acc_old),
    .acc_new   (acc_new)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (start_go) state_nxt = ST_PTR0;
      ST_PTR0: state_nxt = ST_LD0;
      ST_LD0:  state_nxt = ST_PTR;
      ST_PTR: begin
        if (k_r == outer_n_r) state_nxt = (out_n_r == '0) ? ST_IDLE : ST_OUT;
        else                  state_nxt = ST_LDE;
      end
      ST_LDE:  state_nxt = ST_ENT;
      ST_ENT:  state_nxt = (p_r < end_r) ? ST_ENTW : ST_PTR;
      ST_ENTW: state_nxt = skip ? ST_ENT : ST_MUL;
      ST_MUL:  state_nxt = ST_ACC;
      ST_ACC:  state_nxt = ST_ENT;
      ST_OUT:  state_nxt = ST_OUTW;
      ST_OUTW: state_nxt = ST_SEND;
      ST_SEND: begin
        if (out_xfer) state_nxt = out_last_r ? ST_IDLE : ST_OUT;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    out_valid = (state_r == ST_SEND);
    slice_re  = (state_r == ST_PTR0) || (state_r == ST_PTR);
    ent_re    = (state_r == ST_ENT);
    vec_re    = (state_r == ST_ENTW);
    acc_we    = (state_r == ST_ACC);
    alu_ctrl.load = (state_r == ST_MUL);
    case (op_r)
      OP_AX, OP_ATX:          alu_ctrl.kind = K_MUL;
      OP_ROW_MAX, OP_COL_MAX: alu_ctrl.kind = K_MAX;
      default:                alu_ctrl.kind = K_SUM;
    endcase
    k_nxt   = k_r;
    j_nxt   = j_r;
    p_nxt   = p_r;
    end_nxt = end_r;
    tgt_nxt = tgt_r;
    case (state_r)
      ST_IDLE: begin
        k_nxt = '0;
        j_nxt = '0;
      end
      ST_LD0: p_nxt = slice_clamp;
      ST_LDE: end_nxt = slice_clamp;
      ST_ENT: begin
        if (p_r < end_r) begin
          p_nxt = p_r + 1'b1;
        end else begin
          // the next slice starts where this one was declared to end
          p_nxt = end_r;
          k_nxt = k_r + 1'b1;
        end
      end
      ST_ENTW: tgt_nxt = op_r[0] ? c_idx : r_idx;
      ST_SEND: if (out_xfer) j_nxt = j_r + 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      j_r     <= j_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r   <= p_nxt;
    end_r <= end_nxt;
    tgt_r <= tgt_nxt;
    if (start_go) begin
      op_r      <= in_operation;
      run_fmt_r <= fmt_r;
      outer_n_r <= fmt_r ? cols_c : rows_c;
      inner_n_r <= fmt_r ? rows_c : cols_c;
      out_n_r   <= in_operation[0] ? cols_c : rows_c;
    end
  end

  // floor to Q16.16 and saturate
  assign acc_fin = acc_old;
  always_ff @(posedge clk) begin
    if (state_r == ST_OUTW) begin
      out_pos_r  <= INNER_W'(j_r);
      out_last_r <= (32'(j_r) + 1 == 32'(out_n_r));
      if (acc_fin[ACC_W-1:47] == '0 || acc_fin[ACC_W-1:47] == '1) begin
        out_val_r <= acc_fin[47:16];
      end else if (acc_fin[ACC_W-1]) begin
        out_val_r <= {1'b1, {(NUM_W-1){1'b0}}};
      end else begin
        out_val_r <= {1'b0, {(NUM_W-1){1'b1}}};
      end
    end
  end

  assign out_element_position = out_pos_r;
  assign out_element_value    = out_val_r;
  assign out_last             = out_last_r;

  `SMVE_ASSERT_NOW(a_out_only_send, out_valid, state_r == ST_SEND, "result shown outside send state")
  `SMVE_ASSERT_NEXT(a_start_runs, start_go, state_r == ST_PTR0, "start did not begin a run")
  `SMVE_ASSERT_NOW(a_acc_addr, acc_we, 32'(tgt_r) < MAX_DIM, "accumulator write out of range")
  `SMVE_ASSERT_NEXT(a_last_idle, out_xfer && out_last, state_r == ST_IDLE, "run continued after last")

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sparse matrix/vector engine. Loads CSR and CSC
// matrices, runs all operations, and compares every output element with a
// built-in predictor. Covers saturation, empty and out-of-range cases, bursty
// input, random output stall and a long output hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import smve_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int DRAIN_WAIT     = 1600;

  typedef struct {
    logic [INNER_W-1:0]      pos;
    logic signed [NUM_W-1:0] val;
    logic                    last;
  } element_t;

  logic clk;
  logic rst_n;
  logic in_valid, in_stall;
  action_t in_action;
  logic [SLOT_W-1:0] in_slot;
  logic [PTR_W-1:0] in_pointer_value;
  logic [INNER_W-1:0] in_inner_position;
  logic signed [NUM_W-1:0] in_number_in;
  logic [OP_W-1:0] in_operation;
  logic out_valid, out_stall;
  logic [INNER_W-1:0] out_element_position;
  logic signed [NUM_W-1:0] out_element_value;
  logic out_last;
  logic cfg_valid, cfg_ready;
  cfg_reg_t cfg_index;
  logic [CNT_W-1:0] cfg_data;

  sparse_matrix_vector_engine_core uut (.*);

  // Predictor state
  logic [PTR_W-1:0] slice_start_m [0:64];
  logic [INNER_W-1:0] entry_pos_m [0:255];
  logic [NUM_W-1:0] entry_val_m [0:255];
  logic [NUM_W-1:0] vector_m [0:63];
  bit ptr_written [0:64];
  bit nz_written [0:255];
  bit vec_written [0:63];
  int rows_m, cols_m, fmt_m;
  element_t expected_q[$];

  int errors, items_sent, results_seen, starts_run, cfg_writes;
  int burst_left, idle_cycles, hold_cycles;
  bit no_gaps, quiet_start;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic int clamp_dim(int n);
    return n > 64 ? 64 : n;
  endfunction

  function automatic int clamp_ptr(int p);
    return p > 256 ? 256 : p;
  endfunction

  function automatic longint sat_sum(longint a, longint b);
    logic signed [64:0] s;
    s = 65'(signed'(a)) + 65'(signed'(b));
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return longint'(s[63:0]);
  endfunction

  function automatic logic [31:0] floor_sat(longint acc);
    if (acc >= 64'sh0000_8000_0000_0000) return 32'h7FFF_FFFF;
    if (acc < -64'sh0000_8000_0000_0000) return 32'h8000_0000;
    return 32'(acc >>> 16);
  endfunction

  // Runs one operation over the stored matrix and queues the output vector
  function automatic void run_operation(logic [2:0] op);
    longint acc [0:63];
    int rows, cols, outer_n, inner_n, n, s, e, r, c;
    longint v, mag, prod;
    element_t el;
    quiet_start = 1;
    if (op > OP_COL_L1) return;
    rows = clamp_dim(rows_m);
    cols = clamp_dim(cols_m);
    outer_n = fmt_m ? cols : rows;
    inner_n = fmt_m ? rows : cols;
    for (int i = 0; i < 64; i++) acc[i] = 0;
    for (int k = 0; k < outer_n; k++) begin
      s = clamp_ptr(slice_start_m[k]);
      e = clamp_ptr(slice_start_m[k+1]);
      for (int p = s; p < e; p++) begin
        if (entry_pos_m[p] >= inner_n) continue;
        r = fmt_m ? entry_pos_m[p] : k;
        c = fmt_m ? k : entry_pos_m[p];
        v = longint'(signed'(entry_val_m[p]));
        mag = (v < 0 ? -v : v) * 65536;
        case (op)
          OP_AX: begin
            prod = v * longint'(signed'(vector_m[c]));
            acc[r] = sat_sum(acc[r], prod);
          end
          OP_ATX: begin
            prod = v * longint'(signed'(vector_m[r]));
            acc[c] = sat_sum(acc[c], prod);
          end
          OP_ROW_MAX: if (mag > acc[r]) acc[r] = mag;
          OP_COL_MAX: if (mag > acc[c]) acc[c] = mag;
          OP_ROW_L1: acc[r] = sat_sum(acc[r], mag);
          default: acc[c] = sat_sum(acc[c], mag);
        endcase
      end
    end
    n = op[0] ? cols : rows;
    if (n > 0) quiet_start = 0;
    for (int k = 0; k < n; k++) begin
      el.pos = k[5:0];
      el.val = floor_sat(acc[k]);
      el.last = (k + 1 == n);
      expected_q = {expected_q, el};
    end
  endfunction

  function automatic void absorb_item(action_t a, int slot, int ptr, int inner,
                                      logic [31:0] num, logic [2:0] op);
    case (a)
      ACT_LOAD_PTR: if (slot <= 64) begin
        slice_start_m[slot] = ptr[8:0];
        ptr_written[slot] = 1;
      end
      ACT_LOAD_NZ: begin
        entry_pos_m[slot] = inner[5:0];
        entry_val_m[slot] = num;
        nz_written[slot] = 1;
      end
      ACT_LOAD_VEC: if (slot < 64) begin
        vector_m[slot] = num;
        vec_written[slot] = 1;
      end
      default: begin
        starts_run++;
        run_operation(op);
      end
    endcase
  endfunction

  // One input transfer; the sender idles between bursts of random length
  task automatic send_item(action_t a, int slot, int ptr = 0, int inner = 0,
                           logic [31:0] num = 0, logic [2:0] op = 0);
    int gap;
    gap = 0;
    if (!no_gaps) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 6);
        burst_left = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_action <= a;
    in_slot <= slot[7:0];
    in_pointer_value <= ptr[8:0];
    in_inner_position <= inner[5:0];
    in_number_in <= num;
    in_operation <= op;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    absorb_item(a, slot, ptr, inner, num, op);
  endtask

  task automatic wait_idle();
    in_valid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    // a start without results may still be walking nonzeros
    repeat (quiet_start ? DRAIN_WAIT : 20) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int value);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= value[6:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_writes++;
    case (idx)
      CFG_ROW_COUNT: rows_m = value & 'h7F;
      CFG_COL_COUNT: cols_m = value & 'h7F;
      default: fmt_m = value & 1;
    endcase
  endtask

  task automatic set_shape(int rows, int cols, int fmt);
    wait_idle();
    write_reg(CFG_ROW_COUNT, rows);
    write_reg(CFG_COL_COUNT, cols);
    write_reg(CFG_FORMAT, fmt);
    cfg_valid <= 0;
  endtask

  function automatic logic [31:0] rand_number();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(0, 'h3_FFFF)) - 'h2_0000);
      default: return $urandom;
    endcase
  endfunction

  // Load whatever the next start reads that has never been written
  task automatic fill_gaps();
    int outer_n, s, e, vec_n;
    outer_n = fmt_m ? clamp_dim(cols_m) : clamp_dim(rows_m);
    for (int k = 0; k <= outer_n; k++)
      if (!ptr_written[k]) send_item(ACT_LOAD_PTR, k, 0);
    for (int k = 0; k < outer_n; k++) begin
      s = clamp_ptr(slice_start_m[k]);
      e = clamp_ptr(slice_start_m[k+1]);
      for (int p = s; p < e; p++)
        if (!nz_written[p]) send_item(ACT_LOAD_NZ, p, 0, $urandom_range(0, 63), rand_number());
    end
    vec_n = clamp_dim(rows_m > cols_m ? rows_m : cols_m);
    for (int i = 0; i < vec_n; i++)
      if (!vec_written[i]) send_item(ACT_LOAD_VEC, i, 0, 0, rand_number());
  endtask

  task automatic test_saturation();
    set_shape(2, 2, 0);
    send_item(ACT_LOAD_PTR, 0, 0);
    send_item(ACT_LOAD_PTR, 1, 3);
    send_item(ACT_LOAD_PTR, 2, 4);
    send_item(ACT_LOAD_NZ, 0, 0, 0, 32'h8000_0000);
    send_item(ACT_LOAD_NZ, 1, 0, 0, 32'h8000_0000);
    send_item(ACT_LOAD_NZ, 2, 0, 1, 32'h7FFF_FFFF);
    send_item(ACT_LOAD_NZ, 3, 0, 1, 32'h8000_0000);
    send_item(ACT_LOAD_VEC, 0, 0, 0, 32'h8000_0000);
    send_item(ACT_LOAD_VEC, 1, 0, 0, 32'h7FFF_FFFF);
    for (int op = 0; op < 8; op++) send_item(ACT_START, 0, 0, 0, 0, op[2:0]);
    set_shape(2, 2, 1);
    for (int op = 0; op < 6; op++) send_item(ACT_START, 0, 0, 0, 0, op[2:0]);
  endtask

  task automatic test_edge_cases();
    // zero dimensions, ignored slots, oversized pointers and counts
    set_shape(0, 0, 0);
    send_item(ACT_LOAD_PTR, 255, 511);
    send_item(ACT_LOAD_VEC, 200, 0, 0, 32'hFFFF_FFFF);
    send_item(ACT_START, 0, 0, 0, 0, OP_AX);
    send_item(ACT_START, 0, 0, 0, 0, 3'd7);
    set_shape(127, 1, 0);
    // first slice ends past the nonzero store, the next one runs backward
    send_item(ACT_LOAD_PTR, 0, 254);
    send_item(ACT_LOAD_PTR, 1, 400);
    fill_gaps();
    send_item(ACT_START, 0, 0, 0, 0, OP_ROW_L1);
    send_item(ACT_START, 0, 0, 0, 0, OP_ATX);
  endtask

  // Mostly well-formed matrix with random content, noise items and a few starts
  task automatic build_and_run();
    int rows, cols, fmt, outer_n, inner_n, ofs, nz_max;
    rows = $urandom_range(0, 11) == 0 ? 64 : $urandom_range(1, 8);
    cols = $urandom_range(0, 11) == 0 ? 64 : $urandom_range(1, 8);
    if ($urandom_range(0, 15) == 0) rows = $urandom_range(65, 127);
    if ($urandom_range(0, 15) == 0) cols = 0;
    fmt = $urandom_range(0, 1);
    set_shape(rows, cols, fmt);
    outer_n = fmt ? clamp_dim(cols) : clamp_dim(rows);
    inner_n = fmt ? clamp_dim(rows) : clamp_dim(cols);
    nz_max = outer_n > 16 ? 1 : 3;
    ofs = $urandom_range(0, 20);
    for (int k = 0; k <= outer_n; k++) begin
      if ($urandom_range(0, 9) == 0)
        send_item(ACT_LOAD_PTR, k, $urandom_range(0, 511));
      else
        send_item(ACT_LOAD_PTR, k, ofs);
      if ($urandom_range(0, 12) == 0)
        send_item(ACT_LOAD_PTR, $urandom_range(65, 255), $urandom_range(0, 511));
      ofs = clamp_ptr(ofs + $urandom_range(0, nz_max));
    end
    for (int p = 0; p < ofs && p < 256; p++)
      send_item(ACT_LOAD_NZ, p, $urandom_range(0, 511),
                ($urandom_range(0, 9) == 0 || inner_n == 0) ? $urandom_range(0, 63)
                                                           : $urandom_range(0, inner_n - 1),
                rand_number());
    for (int i = 0; i < clamp_dim(rows > cols ? rows : cols); i++) begin
      send_item(ACT_LOAD_VEC, i, 0, 0, rand_number());
      if ($urandom_range(0, 12) == 0)
        send_item(ACT_LOAD_VEC, $urandom_range(64, 255), 0, 0, $urandom);
    end
    fill_gaps();
    repeat ($urandom_range(1, 3))
      send_item(ACT_START, $urandom_range(0, 255), $urandom_range(0, 511),
                $urandom_range(0, 63), $urandom,
                $urandom_range(0, 9) == 0 ? $urandom_range(6, 7) : $urandom_range(0, 5));
  endtask

  task automatic test_random_matrices(int target);
    while (items_sent < target) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      build_and_run();
    end
    no_gaps = 0;
  endtask

  // Receiver holds off while starts keep coming, so the input stalls
  task automatic test_output_holdoff();
    set_shape(8, 8, 0);
    fill_gaps();
    hold_cycles = 600;
    no_gaps = 1;
    for (int i = 0; i < 6; i++) send_item(ACT_START, 0, 0, 0, 0, i[2:0]);
    send_item(ACT_LOAD_VEC, 3, 0, 0, rand_number());
    send_item(ACT_START, 0, 0, 0, 0, OP_AX);
    no_gaps = 0;
  endtask

  // Output stall: pattern picked by stall_phase bits 7:6, plus the hold-off count
  int stall_phase;
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1;
    end else begin
      case (stall_phase[7:6])
        2'd0: out_stall <= 0;
        2'd1: out_stall <= ($urandom_range(0, 9) < 3);
        2'd2: out_stall <= stall_phase[1];
        default: out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  // Result checker
  always @(posedge clk) begin
    element_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result pos=%0d value=%h last=%b", $time,
                 out_element_position, out_element_value, out_last);
      end else begin
        want = expected_q.pop_front();
        if (out_element_position !== want.pos) begin
          errors++;
          $display("%0t: position expected %0d actual %0d", $time, want.pos,
                   out_element_position);
        end
        if (out_element_value !== want.val) begin
          errors++;
          $display("%0t: value at %0d expected %h actual %h", $time, want.pos,
                   want.val, out_element_value);
        end
        if (out_last !== want.last) begin
          errors++;
          $display("%0t: last at %0d expected %b actual %b", $time, want.pos,
                   want.last, out_last);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
        || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, expected_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_action = ACT_LOAD_PTR;
    in_slot = 0;
    in_pointer_value = 0;
    in_inner_position = 0;
    in_number_in = 0;
    in_operation = 0;
    out_stall = 0;
    cfg_valid = 0;
    cfg_index = CFG_ROW_COUNT;
    cfg_data = 0;
    stall_phase = 0;
    hold_cycles = 0;
    idle_cycles = 0;
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    starts_run = 0;
    cfg_writes = 0;
    burst_left = 0;
    no_gaps = 0;
    quiet_start = 0;
    rows_m = 0;
    cols_m = 0;
    fmt_m = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    test_saturation();
    test_edge_cases();
    test_output_holdoff();
    test_random_matrices(310);

    wait_idle();
    repeat (200) @(posedge clk);
    $display("Sent %0d items (%0d starts), checked %0d output elements, %0d register writes",
             items_sent, starts_run, results_seen, cfg_writes);
    $display("CSR and CSC, all six operations, saturation, empty and ignored cases");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
